[hw/rtl/iegs_pkg.sv]
package iegs_pkg;

    // sizes of the stores
    localparam int VERT_W     = 10;
    localparam int VERTICES   = 1024;
    localparam int EDGES      = 4096;
    localparam int EDGE_AW    = 12;
    localparam int ECNT_W     = 13;
    localparam int ADJ_DEPTH  = 8192;
    localparam int ADJ_AW     = 13;
    localparam int OFF_DEPTH  = 1025;
    localparam int OFF_AW     = 11;
    localparam int DEG_W      = 14;
    localparam int SCNT_W     = 11;
    localparam int MAX_DEGREE = 64;

    // item modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_BUILD  = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;
    localparam logic [1:0] MODE_INDUCE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DEG_OVF   = 3'd2;
    localparam logic [2:0] ST_NOT_BUILT = 3'd3;
    localparam logic [2:0] ST_BAD_PICK  = 3'd4;
    localparam logic [2:0] ST_POOL_MT   = 3'd5;
    localparam logic [2:0] ST_NO_VERTEX = 3'd6;

    // vertex flag bits
    localparam int FL_INS  = 0;
    localparam int FL_PROC = 1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  vertex_a;
        logic [9:0]  vertex_b;
        logic [11:0] pick_index;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  added_count;
        logic [9:0]  added_first;
        logic [9:0]  added_second;
        logic [10:0] sampled_total;
        logic        target_reached;
        logic        edge_valid;
        logic [9:0]  edge_from;
        logic [9:0]  edge_to;
        logic        last;
    } result_t;

endpackage

[hw/rtl/induced_edge_graph_sampler.sv]
// channel   | handshake                       | beat
// ----------+---------------------------------+--------------------------
// item      | start, busy                     | iegs_pkg::item_t
// result    | result_valid (one-cycle strobe) | iegs_pkg::result_t
// config    | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// build runs clear, count, prefix and scatter sweeps, each bound by one
// memory port access per cycle.
// each result appears on the cycle after the step that makes it.
// reset clears counters and flags; the stores need no clearing pass, build
// clears the vertex maps and degree counts itself.
// the receiver cannot stall: busy alone holds items off.
module induced_edge_graph_sampler (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  iegs_pkg::item_t   item,
    output logic              result_valid,
    output iegs_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;
    localparam logic [4:0] S_CNT_RD = 5'd2;
    localparam logic [4:0] S_CNT_A  = 5'd3;
    localparam logic [4:0] S_CNT_WA = 5'd4;
    localparam logic [4:0] S_CNT_RB = 5'd5;
    localparam logic [4:0] S_CNT_WB = 5'd6;
    localparam logic [4:0] S_PFX_RD = 5'd7;
    localparam logic [4:0] S_PFX_W  = 5'd8;
    localparam logic [4:0] S_SC_RD  = 5'd9;
    localparam logic [4:0] S_SC_A   = 5'd10;
    localparam logic [4:0] S_SC_WA  = 5'd11;
    localparam logic [4:0] S_SC_RB  = 5'd12;
    localparam logic [4:0] S_SC_WB  = 5'd13;
    localparam logic [4:0] S_SM_RP  = 5'd14;
    localparam logic [4:0] S_SM_RL  = 5'd15;
    localparam logic [4:0] S_SM_FA  = 5'd16;
    localparam logic [4:0] S_SM_RB  = 5'd17;
    localparam logic [4:0] S_SM_FB  = 5'd18;
    localparam logic [4:0] S_SM_W1  = 5'd19;
    localparam logic [4:0] S_SM_W2  = 5'd20;
    localparam logic [4:0] S_IN_L   = 5'd21;
    localparam logic [4:0] S_IN_O0  = 5'd22;
    localparam logic [4:0] S_IN_O1  = 5'd23;
    localparam logic [4:0] S_IN_O2  = 5'd24;
    localparam logic [4:0] S_IN_J   = 5'd25;
    localparam logic [4:0] S_IN_D   = 5'd26;
    localparam logic [4:0] S_IN_F   = 5'd27;
    localparam logic [4:0] S_IN_END = 5'd28;

    localparam int VW = iegs_pkg::VERT_W;
    localparam int DW = iegs_pkg::DEG_W;

    // control registers
    logic [4:0]                    state_reg, state_next;
    logic [iegs_pkg::ECNT_W-1:0]   total_reg, total_next;
    logic [iegs_pkg::ECNT_W-1:0]   pool_reg, pool_next;
    logic [iegs_pkg::SCNT_W-1:0]   count_reg, count_next;
    logic [iegs_pkg::SCNT_W-1:0]   cursor_reg, cursor_next;
    logic                          built_reg, built_next;
    logic                          ovf_reg, ovf_next;
    logic                          pend_reg, pend_next;
    logic                          vld_reg, vld_next;
    logic [iegs_pkg::SCNT_W-1:0]   target_reg;
    logic [iegs_pkg::ECNT_W-1:0]   idx_reg, idx_next;

    // payload registers
    logic [DW-1:0]                 acc_reg, acc_next;
    logic [DW-1:0]                 j_reg, j_next;
    logic [DW-1:0]                 stop_reg, stop_next;
    logic [VW-1:0]                 ea_reg, ea_next;
    logic [VW-1:0]                 eb_reg, eb_next;
    logic [VW-1:0]                 cur_reg, cur_next;
    logic [VW-1:0]                 d_reg, d_next;
    logic [VW-1:0]                 pto_reg, pto_next;
    logic [2*VW-1:0]               el_reg, el_next;
    logic [iegs_pkg::EDGE_AW-1:0]  pick_reg, pick_next;
    logic [iegs_pkg::EDGE_AW-1:0]  lpos_reg, lpos_next;
    logic [1:0]                    ac_reg, ac_next;
    logic [VW-1:0]                 af_reg, af_next;
    logic [VW-1:0]                 as_reg, as_next;
    iegs_pkg::result_t             res_reg, res_next;

    // memory ports
    logic                          e_we;
    logic [iegs_pkg::EDGE_AW-1:0]  e_wa, e_ra;
    logic [2*VW-1:0]               e_wd, e_rd;
    logic                          g_we;
    logic [VW-1:0]                 g_wa, g_ra;
    logic [DW-1:0]                 g_wd, g_rd;
    logic                          o_we;
    logic [iegs_pkg::OFF_AW-1:0]   o_wa, o_ra;
    logic [DW-1:0]                 o_wd, o_rd;
    logic                          a_we;
    logic [iegs_pkg::ADJ_AW-1:0]   a_wa, a_ra;
    logic [VW-1:0]                 a_wd, a_rd;
    logic                          l_we;
    logic [VW-1:0]                 l_wa, l_ra, l_wd, l_rd;
    logic                          f_we;
    logic [VW-1:0]                 f_wa, f_ra;
    logic [1:0]                    f_wd, f_rd;

    logic [DW-1:0]                 sum;
    logic [DW-1:0]                 dec;
    logic                          accept;
    logic                          cfg_wr;

    // edge store, both endpoints in one word
    iegs_ram #(.WIDTH(2 * VW), .DEPTH(iegs_pkg::EDGES)) u_edge (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
    );

    // degree counts, then fill pointers during scatter
    iegs_ram #(.WIDTH(DW), .DEPTH(iegs_pkg::VERTICES)) u_deg (
        .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd)
    );

    iegs_ram #(.WIDTH(DW), .DEPTH(iegs_pkg::OFF_DEPTH)) u_off (
        .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
    );

    iegs_ram #(.WIDTH(VW), .DEPTH(iegs_pkg::ADJ_DEPTH)) u_adj (
        .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd)
    );

    iegs_ram #(.WIDTH(VW), .DEPTH(iegs_pkg::VERTICES)) u_list (
        .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
    );

    // in-sample and processed bits per vertex
    iegs_ram #(.WIDTH(2), .DEPTH(iegs_pkg::VERTICES)) u_flag (
        .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign sum    = acc_reg + g_rd;
    assign dec    = g_rd - DW'(1);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {21'd0, target_reg};

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        pool_next   = pool_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        built_next  = built_reg;
        ovf_next    = ovf_reg;
        pend_next   = pend_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        j_next      = j_reg;
        stop_next   = stop_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        cur_next    = cur_reg;
        d_next      = d_reg;
        pto_next    = pto_reg;
        el_next     = el_reg;
        pick_next   = pick_reg;
        lpos_next   = lpos_reg;
        ac_next     = ac_reg;
        af_next     = af_reg;
        as_next     = as_reg;
        vld_next    = 1'b0;
        res_next    = '0;

        e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
        g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
        o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
        a_we = 1'b0; a_wa = '0; a_wd = '0; a_ra = '0;
        l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
        f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next.last = 1'b1;
                    case (item.mode)
                        iegs_pkg::MODE_LOAD:
                        begin
                            vld_next = 1'b1;
                            if (total_reg[iegs_pkg::ECNT_W-1])
                            begin
                                res_next.status = iegs_pkg::ST_FULL;
                            end
                            else
                            begin
                                e_we       = 1'b1;
                                e_wa       = total_reg[iegs_pkg::EDGE_AW-1:0];
                                e_wd       = {item.vertex_a, item.vertex_b};
                                total_next = total_reg + 1'b1;
                                built_next = 1'b0;
                            end
                        end
                        iegs_pkg::MODE_BUILD:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                            pool_next   = total_reg;
                            built_next  = 1'b0;
                            ovf_next    = 1'b0;
                            idx_next    = '0;
                            state_next  = S_CLR;
                        end
                        iegs_pkg::MODE_SAMPLE:
                        begin
                            if (!built_reg)
                            begin
                                vld_next        = 1'b1;
                                res_next.status = iegs_pkg::ST_NOT_BUILT;
                            end
                            else if (pool_reg == '0)
                            begin
                                vld_next        = 1'b1;
                                res_next.status = iegs_pkg::ST_POOL_MT;
                            end
                            else if ({1'b0, item.pick_index} >= pool_reg)
                            begin
                                vld_next        = 1'b1;
                                res_next.status = iegs_pkg::ST_BAD_PICK;
                            end
                            else
                            begin
                                pick_next  = item.pick_index;
                                lpos_next  = pool_reg[iegs_pkg::EDGE_AW-1:0] - 1'b1;
                                ac_next    = '0;
                                af_next    = '0;
                                as_next    = '0;
                                state_next = S_SM_RP;
                            end
                        end
                        default:
                        begin
                            if (!built_reg)
                            begin
                                vld_next        = 1'b1;
                                res_next.status = iegs_pkg::ST_NOT_BUILT;
                            end
                            else if (cursor_reg >= count_reg)
                            begin
                                vld_next        = 1'b1;
                                res_next.status = iegs_pkg::ST_NO_VERTEX;
                            end
                            else
                            begin
                                pend_next  = 1'b0;
                                state_next = S_IN_L;
                            end
                        end
                    endcase
                end
            end

            // clear degree counts and vertex maps
            S_CLR:
            begin
                g_we = 1'b1; g_wa = idx_reg[VW-1:0]; g_wd = '0;
                f_we = 1'b1; f_wa = idx_reg[VW-1:0]; f_wd = '0;
                idx_next = idx_reg + 1'b1;
                if (&idx_reg[VW-1:0])
                begin
                    idx_next   = '0;
                    state_next = S_CNT_RD;
                end
            end

            // degree count sweep
            S_CNT_RD:
            begin
                if (idx_reg == total_reg)
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    o_we       = 1'b1;
                    o_wa       = '0;
                    o_wd       = '0;
                    state_next = S_PFX_RD;
                end
                else
                begin
                    e_ra       = idx_reg[iegs_pkg::EDGE_AW-1:0];
                    state_next = S_CNT_A;
                end
            end
            S_CNT_A:
            begin
                ea_next    = e_rd[2*VW-1:VW];
                eb_next    = e_rd[VW-1:0];
                g_ra       = e_rd[2*VW-1:VW];
                state_next = S_CNT_WA;
            end
            S_CNT_WA:
            begin
                g_we = 1'b1; g_wa = ea_reg; g_wd = g_rd + DW'(1);
                state_next = S_CNT_RB;
            end
            S_CNT_RB:
            begin
                g_ra       = eb_reg;
                state_next = S_CNT_WB;
            end
            S_CNT_WB:
            begin
                g_we = 1'b1; g_wa = eb_reg; g_wd = g_rd + DW'(1);
                idx_next   = idx_reg + 1'b1;
                state_next = S_CNT_RD;
            end

            // prefix sum into offsets and fill pointers
            S_PFX_RD:
            begin
                g_ra       = idx_reg[VW-1:0];
                state_next = S_PFX_W;
            end
            S_PFX_W:
            begin
                o_we = 1'b1;
                o_wa = {1'b0, idx_reg[VW-1:0]} + iegs_pkg::OFF_AW'(1);
                o_wd = sum;
                g_we = 1'b1; g_wa = idx_reg[VW-1:0]; g_wd = sum;
                acc_next = sum;
                if (g_rd > DW'(iegs_pkg::MAX_DEGREE))
                begin
                    ovf_next = 1'b1;
                end
                if (&idx_reg[VW-1:0])
                begin
                    idx_next = '0;
                    if (ovf_reg || (g_rd > DW'(iegs_pkg::MAX_DEGREE)))
                    begin
                        vld_next        = 1'b1;
                        res_next.status = iegs_pkg::ST_DEG_OVF;
                        res_next.last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SC_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PFX_RD;
                end
            end

            // scatter neighbours into the adjacency table
            S_SC_RD:
            begin
                if (idx_reg == total_reg)
                begin
                    built_next      = 1'b1;
                    vld_next        = 1'b1;
                    res_next.status = iegs_pkg::ST_OK;
                    res_next.last   = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    e_ra       = idx_reg[iegs_pkg::EDGE_AW-1:0];
                    state_next = S_SC_A;
                end
            end
            S_SC_A:
            begin
                ea_next    = e_rd[2*VW-1:VW];
                eb_next    = e_rd[VW-1:0];
                g_ra       = e_rd[2*VW-1:VW];
                state_next = S_SC_WA;
            end
            S_SC_WA:
            begin
                g_we = 1'b1; g_wa = ea_reg; g_wd = dec;
                a_we = 1'b1; a_wa = dec[iegs_pkg::ADJ_AW-1:0]; a_wd = eb_reg;
                state_next = S_SC_RB;
            end
            S_SC_RB:
            begin
                g_ra       = eb_reg;
                state_next = S_SC_WB;
            end
            S_SC_WB:
            begin
                g_we = 1'b1; g_wa = eb_reg; g_wd = dec;
                a_we = 1'b1; a_wa = dec[iegs_pkg::ADJ_AW-1:0]; a_wd = ea_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = S_SC_RD;
            end

            // sample step: fetch picked and last pool edges
            S_SM_RP:
            begin
                e_ra       = pick_reg;
                state_next = S_SM_RL;
            end
            S_SM_RL:
            begin
                ea_next    = e_rd[2*VW-1:VW];
                eb_next    = e_rd[VW-1:0];
                f_ra       = e_rd[2*VW-1:VW];
                e_ra       = lpos_reg;
                state_next = S_SM_FA;
            end
            S_SM_FA:
            begin
                el_next = e_rd;
                if (!f_rd[iegs_pkg::FL_INS])
                begin
                    f_we = 1'b1; f_wa = ea_reg; f_wd = {f_rd[iegs_pkg::FL_PROC], 1'b1};
                    l_we = 1'b1; l_wa = count_reg[VW-1:0]; l_wd = ea_reg;
                    count_next = count_reg + 1'b1;
                    af_next    = ea_reg;
                    ac_next    = 2'd1;
                end
                state_next = S_SM_RB;
            end
            S_SM_RB:
            begin
                f_ra       = eb_reg;
                state_next = S_SM_FB;
            end
            S_SM_FB:
            begin
                if (!f_rd[iegs_pkg::FL_INS])
                begin
                    f_we = 1'b1; f_wa = eb_reg; f_wd = {f_rd[iegs_pkg::FL_PROC], 1'b1};
                    l_we = 1'b1; l_wa = count_reg[VW-1:0]; l_wd = eb_reg;
                    count_next = count_reg + 1'b1;
                    if (ac_reg == 2'd0)
                    begin
                        af_next = eb_reg;
                    end
                    else
                    begin
                        as_next = eb_reg;
                    end
                    ac_next = ac_reg + 1'b1;
                end
                state_next = S_SM_W1;
            end
            S_SM_W1:
            begin
                e_we = 1'b1; e_wa = pick_reg; e_wd = el_reg;
                state_next = S_SM_W2;
            end
            S_SM_W2:
            begin
                e_we = 1'b1; e_wa = lpos_reg; e_wd = {ea_reg, eb_reg};
                pool_next             = pool_reg - 1'b1;
                vld_next              = 1'b1;
                res_next.status       = iegs_pkg::ST_OK;
                res_next.added_count  = ac_reg;
                res_next.added_first  = af_reg;
                res_next.added_second = as_reg;
                res_next.last         = 1'b1;
                state_next            = S_IDLE;
            end

            // induce step: vertex and its adjacency range
            S_IN_L:
            begin
                l_ra       = cursor_reg[VW-1:0];
                state_next = S_IN_O0;
            end
            S_IN_O0:
            begin
                cur_next   = l_rd;
                o_ra       = {1'b0, l_rd};
                state_next = S_IN_O1;
            end
            S_IN_O1:
            begin
                j_next     = o_rd;
                o_ra       = {1'b0, cur_reg} + iegs_pkg::OFF_AW'(1);
                state_next = S_IN_O2;
            end
            S_IN_O2:
            begin
                stop_next  = o_rd;
                state_next = S_IN_J;
            end
            S_IN_J:
            begin
                if (j_reg == stop_reg)
                begin
                    state_next = S_IN_END;
                end
                else
                begin
                    a_ra       = j_reg[iegs_pkg::ADJ_AW-1:0];
                    j_next     = j_reg + 1'b1;
                    state_next = S_IN_D;
                end
            end
            S_IN_D:
            begin
                d_next     = a_rd;
                f_ra       = a_rd;
                state_next = S_IN_F;
            end
            // one edge held back so the final beat can carry last
            S_IN_F:
            begin
                if (f_rd[iegs_pkg::FL_INS] && !f_rd[iegs_pkg::FL_PROC])
                begin
                    if (pend_reg)
                    begin
                        vld_next            = 1'b1;
                        res_next.edge_valid = 1'b1;
                        res_next.edge_from  = cur_reg;
                        res_next.edge_to    = pto_reg;
                    end
                    pend_next = 1'b1;
                    pto_next  = d_reg;
                end
                state_next = S_IN_J;
            end
            S_IN_END:
            begin
                f_we = 1'b1; f_wa = cur_reg; f_wd = 2'b11;
                cursor_next         = cursor_reg + 1'b1;
                vld_next            = 1'b1;
                res_next.status     = iegs_pkg::ST_OK;
                res_next.edge_valid = pend_reg;
                res_next.edge_from  = pend_reg ? cur_reg : '0;
                res_next.edge_to    = pend_reg ? pto_reg : '0;
                res_next.last       = 1'b1;
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next.sampled_total  = count_reg;
        res_next.target_reached = (count_reg >= target_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            pool_reg   <= '0;
            count_reg  <= '0;
            cursor_reg <= '0;
            built_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            vld_reg    <= 1'b0;
            idx_reg    <= '0;
            target_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            pool_reg   <= pool_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            built_reg  <= built_next;
            ovf_reg    <= ovf_next;
            pend_reg   <= pend_next;
            vld_reg    <= vld_next;
            idx_reg    <= idx_next;
            if (cfg_wr)
            begin
                target_reg <= pwdata[iegs_pkg::SCNT_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        j_reg    <= j_next;
        stop_reg <= stop_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        cur_reg  <= cur_next;
        d_reg    <= d_next;
        pto_reg  <= pto_next;
        el_reg   <= el_next;
        pick_reg <= pick_next;
        lpos_reg <= lpos_next;
        ac_reg   <= ac_next;
        af_reg   <= af_next;
        as_reg   <= as_next;
        res_reg  <= res_next;
    end

    assign result_valid = vld_reg;
    assign result       = res_reg;

    // pool never exceeds the loaded edge count
    assert property (@(posedge clk) disable iff (!rst_n) pool_reg <= total_reg)
        else $error("pool larger than edge store");

    // induce never runs ahead of the sample list
    assert property (@(posedge clk) disable iff (!rst_n) cursor_reg <= count_reg)
        else $error("induce cursor beyond sampled count");

    // a load beat answers on the next cycle with a final result
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.mode == iegs_pkg::MODE_LOAD) |=> (result_valid && result.last))
        else $error("load without result");

    // a successful build leaves an empty sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(built_reg) |-> (count_reg == '0 && cursor_reg == '0))
        else $error("build left sample state behind");

endmodule

[hw/rtl/iegs_ram.sv]
module iegs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
